// File: src/wrf_pkg.sv
// ----------------------------------------------------------------------------
// wrf_pkg: shared types and constants of the window rank filter
// Register indexes, filter kinds, pixel layout and parameter defaults.
// ----------------------------------------------------------------------------
package wrf_pkg;

  localparam int PIX_W = 8;
  localparam int RGB_W = 3 * PIX_W;
  localparam int CFG_W = 11;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  typedef enum logic [1:0] {
    REG_KIND   = 2'd0,
    REG_RADIUS = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_index_t;

  localparam logic [1:0] KIND_MEDIAN = 2'd0;
  localparam logic [1:0] KIND_MAX    = 2'd1;
  localparam logic [1:0] KIND_MIN    = 2'd2;

endpackage

// File: src/wrf_ram.sv
// ----------------------------------------------------------------------------
// wrf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wrf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/wrf_rank.sv
// ----------------------------------------------------------------------------
// wrf_rank: rank selector for one color channel
// One lane per window element ranks it against all others (ties broken by
// position), then a merge stage picks the element whose rank hits the target.
// ----------------------------------------------------------------------------
module wrf_rank import wrf_pkg::*; #(
  parameter int NW = 49
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [PIX_W-1:0]        vals [NW],
  input  logic [NW-1:0]           vmask,
  input  logic [$clog2(NW)-1:0]   target,
  output logic [PIX_W-1:0]        result
);

  localparam int TW = $clog2(NW);

  logic [NW-1:0]    lt      [NW];
  logic [NW-1:0]    a_lt    [NW];
  logic [PIX_W-1:0] a_val   [NW];
  logic [NW-1:0]    a_mask;
  logic [TW-1:0]    a_target;
  logic [TW-1:0]    b_rank  [NW];
  logic [PIX_W-1:0] b_val   [NW];
  logic [NW-1:0]    b_mask;
  logic [TW-1:0]    b_target;
  logic [PIX_W-1:0] pick;

  // lane i: which valid elements sort ahead of element i
  for (genvar i = 0; i < NW; i++) begin : g_lane
    for (genvar j = 0; j < NW; j++) begin : g_cmp
      if (j < i) begin : g_lo
        assign lt[i][j] = vmask[j] && (vals[j] <= vals[i]);
      end else begin : g_hi
        assign lt[i][j] = vmask[j] && (vals[j] < vals[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lt     <= lt;
      a_val    <= vals;
      a_mask   <= vmask;
      a_target <= target;
      for (int i = 0; i < NW; i++) begin
        b_rank[i] <= TW'($countones(a_lt[i]));
      end
      b_val    <= a_val;
      b_mask   <= a_mask;
      b_target <= a_target;
      result   <= pick;
    end
  end

  // ranks are unique among valid elements, so at most one lane hits
  always_comb begin
    pick = '0;
    for (int i = 0; i < NW; i++) begin
      if (b_mask[i] && (b_rank[i] == b_target)) begin
        pick = pick | b_val[i];
      end
    end
  end

endmodule

// File: src/window_rank_filter_rgb.sv
// ----------------------------------------------------------------------------
// window_rank_filter_rgb: per-channel median / max / min over a square window
// Raster RGB stream in, filtered RGB stream out, window clipped at borders.
// ----------------------------------------------------------------------------
// One pixel per clock while the output is not stalled. Each accepted item
// has its line buffer read at the edge that accepts it, then passes window
// shift, lane compare, rank count and merge into the output register; output
// results lag input pixels by radius*image_width + radius transactions, so
// after a frame the source sends that many flush transactions to drain it.
// Line buffers are 2*MAX_RADIUS+1 RAMs of MAX_WIDTH pixels; no clearing pass
// is needed after reset. The whole pipeline holds while a result waits at a
// stalled output.
module window_rank_filter_rgb import wrf_pkg::*; #(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] red_in,
  input  logic [PIX_W-1:0] green_in,
  input  logic [PIX_W-1:0] blue_in,
  input  logic             flush,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] red_out,
  output logic [PIX_W-1:0] green_out,
  output logic [PIX_W-1:0] blue_out,
  output logic             end_of_frame
);

  localparam int NR   = 2 * MAX_RADIUS + 1;
  localparam int NW   = NR * NR;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int HHW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int RDW  = $clog2(MAX_RADIUS + 1);
  localparam int NRW  = $clog2(NR);
  localparam int NCW  = $clog2(NR + 1);
  localparam int NNW  = $clog2(NW + 1);
  localparam int TW   = $clog2(NW);
  localparam int LW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  // configuration
  logic [1:0]    filter_kind, filter_kind_next;
  logic [RDW-1:0] radius, radius_next;
  logic [WW-1:0] img_w, img_w_next;
  logic [HHW-1:0] img_h, img_h_next;
  logic [LW-1:0] lag;
  logic          cfg_restart;

  always_comb begin
    filter_kind_next = filter_kind;
    radius_next      = radius;
    img_w_next       = img_w;
    img_h_next       = img_h;
    cfg_restart      = 1'b0;
    if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_KIND: begin
          filter_kind_next = cfg_data[1:0];
        end
        REG_RADIUS: begin
          cfg_restart = 1'b1;
          if (int'(cfg_data[1:0]) > MAX_RADIUS) radius_next = RDW'(MAX_RADIUS);
          else radius_next = RDW'(cfg_data[1:0]);
        end
        REG_WIDTH: begin
          cfg_restart = 1'b1;
          if (cfg_data == '0) img_w_next = WW'(1);
          else if (int'(cfg_data) > MAX_WIDTH) img_w_next = WW'(MAX_WIDTH);
          else img_w_next = WW'(cfg_data);
        end
        REG_HEIGHT: begin
          cfg_restart = 1'b1;
          if (cfg_data == '0) img_h_next = HHW'(1);
          else if (int'(cfg_data) > MAX_HEIGHT) img_h_next = HHW'(MAX_HEIGHT);
          else img_h_next = HHW'(cfg_data);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_kind <= KIND_MEDIAN;
      radius      <= RDW'(1);
      img_w       <= WW'(RST_W);
      img_h       <= HHW'(RST_H);
      lag         <= LW'(RST_W + 1);
    end else begin
      filter_kind <= filter_kind_next;
      radius      <= radius_next;
      img_w       <= img_w_next;
      img_h       <= img_h_next;
      lag         <= LW'(radius_next) * LW'(img_w_next) + LW'(radius_next);
    end
  end

  // input side: raster counters and line buffer write
  logic           move, accept, take, pixels_in, wr_en, produce, last, col_wrap;
  logic [AW-1:0]  in_col;
  logic [RW-1:0]  in_row;
  logic [NRW-1:0] in_ring;
  logic [AW-1:0]  out_col;
  logic [HW-1:0]  out_row;
  logic [LW-1:0]  lag_count;
  logic [RGB_W-1:0] pix;

  assign move      = !(out_valid && out_stall);
  assign in_stall  = !move;
  assign accept    = in_valid && !in_stall;
  assign pixels_in = in_row >= RW'(img_h);
  // early flush transactions are dropped outright
  assign take      = accept && !(flush && !pixels_in);
  assign wr_en     = take && !pixels_in;
  assign produce   = lag_count == lag;
  assign col_wrap  = (AW + 1)'(in_col) + (AW + 1)'(1) >= (AW + 1)'(img_w);
  assign last      = ((HW + 1)'(out_row) + (HW + 1)'(1) >= (HW + 1)'(img_h))
                  && ((AW + 1)'(out_col) + (AW + 1)'(1) >= (AW + 1)'(img_w));
  assign pix       = {red_in, green_in, blue_in};

  always_ff @(posedge clk) begin
    if (rst || cfg_restart || (take && produce && last)) begin
      in_col    <= '0;
      in_row    <= '0;
      in_ring   <= '0;
      out_col   <= '0;
      out_row   <= '0;
      lag_count <= '0;
    end else if (take) begin
      if (col_wrap) begin
        in_col  <= '0;
        in_row  <= in_row + RW'(1);
        in_ring <= (in_ring == NRW'(NR - 1)) ? '0 : in_ring + NRW'(1);
      end else begin
        in_col <= in_col + AW'(1);
      end
      if (produce) begin
        if ((AW + 1)'(out_col) + (AW + 1)'(1) >= (AW + 1)'(img_w)) begin
          out_col <= '0;
          out_row <= out_row + HW'(1);
        end else begin
          out_col <= out_col + AW'(1);
        end
      end else begin
        lag_count <= lag_count + LW'(1);
      end
    end
  end

  logic [RGB_W-1:0] ram_q [NR];

  for (genvar b = 0; b < NR; b++) begin : g_line
    wrf_ram #(
      .WIDTH (RGB_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .wr_en   (wr_en && (in_ring == NRW'(b))),
      .wr_addr (in_col),
      .wr_data (pix),
      .rd_en   (take),
      .rd_addr (in_col),
      .rd_data (ram_q[b])
    );
  end

  // stage 1: line buffer data returns
  logic             s1_v, s1_res, s1_last;
  logic [RGB_W-1:0] s1_pix;
  logic [NRW-1:0]   s1_ring;
  logic [AW-1:0]    s1_ocol;
  logic [HW-1:0]    s1_orow;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (move) begin
      s1_v <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s1_res  <= produce;
      s1_last <= last;
      s1_pix  <= pix;
      s1_ring <= in_ring;
      s1_ocol <= out_col;
      s1_orow <= out_row;
    end
  end

  // column assembly: row offset j above the newest row, newest row bypassed
  logic [RGB_W-1:0] column [NR];
  logic [NR-1:0]    row_ok, col_ok;

  assign column[0] = s1_pix;
  for (genvar j = 1; j < NR; j++) begin : g_col
    logic [NRW:0] src;
    assign src = ((NRW + 1)'(s1_ring) + (NRW + 1)'(NR - j) >= (NRW + 1)'(NR))
               ? (NRW + 1)'(s1_ring) + (NRW + 1)'(NR - j) - (NRW + 1)'(NR)
               : (NRW + 1)'(s1_ring) + (NRW + 1)'(NR - j);
    assign column[j] = ram_q[src[NRW-1:0]];
  end

  // window clipping: column k holds out_col + r - k, row j holds out_row + r - j
  for (genvar k = 0; k < NR; k++) begin : g_mask
    assign col_ok[k] = (k <= 2 * int'(radius))
                    && (int'(s1_ocol) + int'(radius) >= k)
                    && (int'(s1_ocol) + int'(radius) - k <= int'(img_w) - 1);
    assign row_ok[k] = (k <= 2 * int'(radius))
                    && (int'(s1_orow) + int'(radius) >= k)
                    && (int'(s1_orow) + int'(radius) - k <= int'(img_h) - 1);
  end

  // stage 2: window shift register
  logic [RGB_W-1:0] win [NR][NR];
  logic             s2_res, s2_last;
  logic [NR-1:0]    s2_row_ok, s2_col_ok;
  logic [NCW-1:0]   s2_nrows, s2_ncols;

  always_ff @(posedge clk) begin
    if (move && s1_v) begin
      win[0] <= column;
      for (int k = 1; k < NR; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_res <= 1'b0;
    end else if (move) begin
      s2_res <= s1_v && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s2_last   <= s1_last;
      s2_row_ok <= row_ok;
      s2_col_ok <= col_ok;
      s2_nrows  <= NCW'($countones(row_ok));
      s2_ncols  <= NCW'($countones(col_ok));
    end
  end

  // rank target and lane inputs
  logic [NNW-1:0]   n_elem;
  logic [TW-1:0]    target;
  logic [NW-1:0]    vmask;
  logic [PIX_W-1:0] red_v [NW], green_v [NW], blue_v [NW];

  assign n_elem = NNW'(s2_nrows) * NNW'(s2_ncols);

  always_comb begin
    unique case (filter_kind)
      KIND_MAX: target = TW'(n_elem - NNW'(1));
      KIND_MIN: target = '0;
      default:  target = TW'(n_elem >> 1);
    endcase
  end

  for (genvar k = 0; k < NR; k++) begin : g_ek
    for (genvar j = 0; j < NR; j++) begin : g_ej
      assign vmask[k*NR + j]   = s2_col_ok[k] && s2_row_ok[j];
      assign red_v[k*NR + j]   = win[k][j][RGB_W-1 -: PIX_W];
      assign green_v[k*NR + j] = win[k][j][2*PIX_W-1 -: PIX_W];
      assign blue_v[k*NR + j]  = win[k][j][PIX_W-1:0];
    end
  end

  wrf_rank #(.NW(NW)) u_rank_red (
    .clk (clk), .en (move), .vals (red_v), .vmask (vmask), .target (target),
    .result (red_out)
  );

  wrf_rank #(.NW(NW)) u_rank_green (
    .clk (clk), .en (move), .vals (green_v), .vmask (vmask), .target (target),
    .result (green_out)
  );

  wrf_rank #(.NW(NW)) u_rank_blue (
    .clk (clk), .en (move), .vals (blue_v), .vmask (vmask), .target (target),
    .result (blue_out)
  );

  // result flags ride alongside the rank pipeline
  logic s3_res, s3_last, s4_res, s4_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_res    <= 1'b0;
      s4_res    <= 1'b0;
      out_valid <= 1'b0;
    end else if (move) begin
      s3_res    <= s2_res;
      s4_res    <= s3_res;
      out_valid <= s4_res;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s3_last      <= s2_last;
      s4_last      <= s3_last;
      end_of_frame <= s4_last;
    end
  end

  // checks
  a_lag_bound: assert property (@(posedge clk) disable iff (rst)
    lag_count <= lag)
    else $error("lag counter ran past the lag");

  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    in_ring < NRW'(NR))
    else $error("line buffer ring index out of range");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    take && produce && last |=> in_col == '0 && in_row == '0 && lag_count == '0)
    else $error("counters not cleared after last output of frame");

  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    (AW + 1)'(out_col) < (AW + 1)'(img_w))
    else $error("output column beyond image width");

  a_no_move_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(s4_res) && $stable(lag_count))
    else $error("pipeline advanced under output stall");

endmodule

// File: test/tb_window_rank_filter_rgb.sv
// ----------------------------------------------------------------------------
// tb_window_rank_filter_rgb: self-checking bench for the window rank filter
// Drives raster frames, early and trailing flushes and register writes with
// random idle and stall bursts. Every output transaction is checked against
// a behavioral window predictor kept in step with each accepted input.
// ----------------------------------------------------------------------------
module tb_window_rank_filter_rgb;
  import wrf_pkg::*;

  localparam int RING      = 2 * DEF_MAX_RADIUS + 1;
  localparam int SETTLE    = 20;
  localparam int IDLE_MAX  = 2000;
  localparam int ITEM_GOAL = 1700;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eof;
  } pix_out_t;

  typedef struct packed {
    logic             is_cfg;
    reg_index_t       idx;
    logic [CFG_W-1:0] data;
    logic             flush;
    logic [23:0]      pix;
    logic             chk;
    logic [23:0]      epix;
    logic             eeof;
  } row_t;

  localparam int NROWS = 21;
  localparam row_t DIRECTED [NROWS] = '{
    '{1'b1, REG_RADIUS, 11'd0,     1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b1, REG_WIDTH,  11'd2,     1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b1, REG_HEIGHT, 11'd2,     1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b1, REG_KIND,   11'd1,     1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    // early flush is dropped
    '{1'b0, REG_KIND,   11'd0,     1'b1, 24'h123456, 1'b0, 24'h0,      1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'h00ff00, 1'b1, 24'h00ff00, 1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'hff00ff, 1'b1, 24'hff00ff, 1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'h01807f, 1'b1, 24'h01807f, 1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'h8001fe, 1'b1, 24'h8001fe, 1'b1},
    // unused selector, masked radius, zero height saturates to one row
    '{1'b1, REG_KIND,   11'h7ff,   1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b1, REG_RADIUS, 11'h7fd,   1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b1, REG_WIDTH,  11'd3,     1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b1, REG_HEIGHT, 11'd0,     1'b0, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'h000000, 1'b0, 24'h0,      1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'h102030, 1'b0, 24'h0,      1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b1, 24'h0,      1'b0, 24'h0,      1'b0},
    // pixel during padding counts as padding
    '{1'b0, REG_KIND,   11'd0,     1'b0, 24'habcdef, 1'b0, 24'h0,      1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b1, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b0, REG_KIND,   11'd0,     1'b1, 24'h0,      1'b0, 24'h0,      1'b0},
    '{1'b1, REG_KIND,   11'd2,     1'b0, 24'h0,      1'b0, 24'h0,      1'b0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       red_in = '0, green_in = '0, blue_in = '0;
  logic             flush = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       red_out, green_out, blue_out;
  logic             end_of_frame;

  window_rank_filter_rgb u_top (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [23:0]  line_ring [RING][DEF_MAX_WIDTH];
  int unsigned  kind_reg = 0, radius_reg = 1, width_reg = 1024, height_reg = 1024;
  int unsigned  in_r = 0, in_c = 0, out_r = 0, out_c = 0;
  pix_out_t     pending_pix [$];

  int  errors = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;
  int  stall_left = 0;

  function automatic int unsigned clip_size(int unsigned v, int unsigned hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  function automatic logic [7:0] rank_pick(int vals[49], int n, int unsigned kind);
    int best, v, j;
    if (kind == KIND_MAX) begin
      best = 0;
      for (int i = 0; i < n; i++) if (vals[i] > best) best = vals[i];
      return best[7:0];
    end
    if (kind == KIND_MIN) begin
      best = 255;
      for (int i = 0; i < n; i++) if (vals[i] < best) best = vals[i];
      return best[7:0];
    end
    for (int i = 1; i < n; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return vals[n/2][7:0];
  endfunction

  task automatic predict_window(logic fl, logic [23:0] pix);
    int unsigned w, h, rr, lag, idx, r0, r1, c0, c1, kind;
    int          rv [49], gv [49], bv [49];
    int          n;
    logic [23:0] p;
    pix_out_t    res;
    w = clip_size(width_reg, DEF_MAX_WIDTH);
    h = clip_size(height_reg, DEF_MAX_HEIGHT);
    rr = radius_reg;
    lag = rr * w + rr;
    if (fl && in_r < h) return;
    if (in_r < h) line_ring[in_r % RING][in_c] = pix;
    idx = in_r * w + in_c;
    in_c++;
    if (in_c >= w) begin
      in_c = 0;
      in_r++;
    end
    if (idx < lag) return;
    r0 = out_r > rr ? out_r - rr : 0;
    r1 = out_r + rr < h ? out_r + rr : h - 1;
    c0 = out_c > rr ? out_c - rr : 0;
    c1 = out_c + rr < w ? out_c + rr : w - 1;
    n = 0;
    for (int unsigned y = r0; y <= r1; y++)
      for (int unsigned x = c0; x <= c1; x++) begin
        p = line_ring[y % RING][x];
        rv[n] = p[23:16];
        gv[n] = p[15:8];
        bv[n] = p[7:0];
        n++;
      end
    kind = kind_reg == 3 ? KIND_MEDIAN : kind_reg;
    res.red = rank_pick(rv, n, kind);
    res.green = rank_pick(gv, n, kind);
    res.blue = rank_pick(bv, n, kind);
    res.eof = (out_r + 1 >= h) && (out_c + 1 >= w);
    pending_pix.push_back(res);
    if (res.eof) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // caller is at a rising edge with the input side idle
  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_KIND:   kind_reg = data & 3;
      REG_RADIUS: radius_reg = data & 3;
      REG_WIDTH:  width_reg = data;
      REG_HEIGHT: height_reg = data;
    endcase
    if (idx != REG_KIND) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end
  endtask

  task automatic send_pixel(logic fl, logic [23:0] pix);
    int gap;
    in_valid <= 1'b1;
    flush <= fl;
    {red_in, green_in, blue_in} <= pix;
    do @(posedge clk); while (in_stall);
    predict_window(fl, pix);
    items_sent++;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the source until every expected transaction is out, then settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_write <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_pix();
    logic [23:0] p;
    p = 24'($urandom);
    case ($urandom_range(0, 7))
      0: p = 24'h000000;
      1: p = 24'hffffff;
      default: ;
    endcase
    return p;
  endfunction

  task automatic run_frame(int unsigned cut);
    int unsigned w, h, rr, total;
    w = clip_size(width_reg, DEF_MAX_WIDTH);
    h = clip_size(height_reg, DEF_MAX_HEIGHT);
    rr = radius_reg;
    total = w * h + rr * w + rr;
    for (int unsigned i = 0; i < total && i < cut; i++) begin
      if (i < w * h) begin
        if ($urandom_range(0, 15) == 0) send_pixel(1'b1, rand_pix());
        send_pixel(1'b0, rand_pix());
      end else begin
        send_pixel($urandom_range(0, 4) != 0, rand_pix());
      end
    end
  endtask

  // output side: random stall bursts, checking against the oldest prediction
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pix.size() == 0) begin
        report("unexpected output transaction", 1, 0);
      end else begin
        want = pending_pix.pop_front();
        if (red_out !== want.red) report("red", red_out, want.red);
        if (green_out !== want.green) report("green", green_out, want.green);
        if (blue_out !== want.blue) report("blue", blue_out, want.blue);
        if (end_of_frame !== want.eof) report("end_of_frame", end_of_frame, want.eof);
      end
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit in_stream;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    in_stream = 1'b0;
    foreach (DIRECTED[k]) begin
      if (DIRECTED[k].is_cfg) begin
        if (in_stream) wait_idle();
        in_stream = 1'b0;
        write_reg(DIRECTED[k].idx, DIRECTED[k].data);
      end else begin
        if (!in_stream) cfg_write <= 1'b0;
        in_stream = 1'b1;
        send_pixel(DIRECTED[k].flush, DIRECTED[k].pix);
        if (DIRECTED[k].chk) begin
          if (pending_pix.size() == 0 ||
              pending_pix[$] !== {DIRECTED[k].epix, DIRECTED[k].eeof})
            report("directed row", k, 0);
        end
      end
    end
    wait_idle();

    // saturation extremes: widest line, an oversized height, then zero sizes
    write_reg(REG_RADIUS, 11'd0);
    write_reg(REG_WIDTH, 11'h7ff);
    write_reg(REG_HEIGHT, 11'd1);
    cfg_write <= 1'b0;
    run_frame(32'hffffffff);
    wait_idle();
    write_reg(REG_KIND, CFG_W'(KIND_MAX));
    write_reg(REG_WIDTH, 11'd1);
    write_reg(REG_HEIGHT, 11'h7ff);
    cfg_write <= 1'b0;
    run_frame(32'd40);
    wait_idle();
    write_reg(REG_KIND, CFG_W'(KIND_MIN));
    write_reg(REG_RADIUS, 11'd0);
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd0);
    cfg_write <= 1'b0;
    run_frame(32'hffffffff);
    run_frame(32'hffffffff);
    wait_idle();

    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL * 4 / 5) quiet = 1'b1;
      write_reg(REG_KIND,
                CFG_W'($urandom_range(0, 3) | ($urandom_range(0, 511) << 2)));
      if ($urandom_range(0, 3) != 0) write_reg(REG_RADIUS, CFG_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) != 0) write_reg(REG_WIDTH, CFG_W'($urandom_range(1, 12)));
      if ($urandom_range(0, 3) != 0) write_reg(REG_HEIGHT, CFG_W'($urandom_range(1, 10)));
      cfg_write <= 1'b0;
      repeat ($urandom_range(1, 3)) begin
        // occasionally cut a frame short; the next size write restarts it
        if ($urandom_range(0, 9) == 0) run_frame($urandom_range(1, 60));
        else run_frame(32'hffffffff);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
